@@ src/pending_request_id_table_assert.svh @@
// Assertion macros for the pending request ID table.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PENDING_REQUEST_ID_TABLE_ASSERT_SVH
`define PENDING_REQUEST_ID_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRIT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/prit_pkg.sv @@
// Shared types and codes for the pending request ID table.
// No dependencies.
`timescale 1ns / 1ps

package prit_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_EXPIRE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET = 32'd2000;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] client_txn;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [31:0] time_ms;
        logic [9:0]  request_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  assigned_id;
        logic [15:0] out_client_id;
        logic [15:0] out_query_type;
        logic [15:0] out_query_class;
        logic [31:0] out_start_time;
        logic [9:0]  active_entries;
    } rsp_t;

    typedef struct packed {
        logic [15:0] client_txn;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [31:0] start_time;
    } rec_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
    } slot_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
        logic fail;
        logic clr_step;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic issue_done;
        logic rd_pending;
        logic clr_last;
    } dp_sts_t;

endpackage

@@ src/prit_ram.sv @@
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module prit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/prit_ctrl.sv @@
// Controller state machine for the pending request ID table.
// Depends on prit_pkg for the command and status structs.
`timescale 1ns / 1ps

module prit_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output prit_pkg::dp_cmd_t cmd,
    input  prit_pkg::dp_sts_t sts
);

    import prit_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                    busy_next  = 1'b1;
                end
            end
            S_SCAN:
            begin
                priority if (sts.hit)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
                else if (sts.issue_done && !sts.rd_pending)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
                else
                begin
                    cmd.issue = !sts.issue_done;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

@@ src/prit_dp.sv @@
// Datapath for the pending request ID table: slot memory, scan address, counters, result.
// Depends on prit_pkg and prit_ram.
`timescale 1ns / 1ps

module prit_dp #(
    parameter int ID_COUNT = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  prit_pkg::req_t    request,
    input  logic              timeout_we,
    input  logic [31:0]       timeout_data,
    input  prit_pkg::dp_cmd_t cmd,
    output prit_pkg::dp_sts_t sts,
    output logic              done,
    output prit_pkg::rsp_t    result
);

    import prit_pkg::*;

    localparam int IDW = $clog2(ID_COUNT);
    localparam int XW  = (IDW > 10) ? IDW : 10;
    localparam int LW  = IDW + 1;
    localparam int MW  = $bits(slot_t);
    localparam logic [IDW-1:0] LAST_ID  = IDW'(ID_COUNT - 1);
    localparam logic [IDW-1:0] FIRST_ID = IDW'(1);

    function automatic logic [9:0] to10(input logic [IDW-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        return w[9:0];
    endfunction

    function automatic logic [IDW-1:0] wrap_next(input logic [IDW-1:0] v);
        return (v == LAST_ID) ? FIRST_ID : v + FIRST_ID;
    endfunction

    logic [31:0]    timeout_reg;
    logic [IDW-1:0] ptr_reg,      ptr_next;
    logic [IDW-1:0] count_reg,    count_next;
    logic [IDW-1:0] addr_reg,     addr_next;
    logic [LW-1:0]  left_reg,     left_next;
    logic           rd_vld_reg,   rd_vld_next;
    logic [IDW-1:0] rd_addr_reg,  rd_addr_next;
    logic [IDW-1:0] clr_addr_reg, clr_addr_next;
    logic           done_reg,     done_next;
    req_t           item_reg,     item_next;
    rsp_t           result_reg,   result_next;

    logic           ram_we;
    logic [IDW-1:0] ram_waddr;
    slot_t          ram_wdata;
    logic [MW-1:0]  ram_rdata;
    slot_t          rd_slot;
    rec_t           new_rec;
    rec_t           out_rec;
    logic [31:0]    age;
    logic           hit;
    logic           rid_ok;
    logic [XW-1:0]  rid_wide;
    logic           is_insert;
    logic           frees_slot;

    prit_ram #(
        .WIDTH (MW),
        .DEPTH (ID_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_slot    = slot_t'(ram_rdata);
    assign age        = item_reg.time_ms - rd_slot.rec.start_time;
    assign is_insert  = (item_reg.command == CMD_INSERT);
    assign frees_slot = (item_reg.command == CMD_REMOVE) || (item_reg.command == CMD_EXPIRE);
    assign rid_wide   = XW'(request.request_id);
    assign rid_ok     = (request.request_id != 10'd0)
                        && (32'(request.request_id) < 32'(ID_COUNT));

    assign new_rec.client_txn  = item_reg.client_txn;
    assign new_rec.query_type  = item_reg.query_type;
    assign new_rec.query_class = item_reg.query_class;
    assign new_rec.start_time  = item_reg.time_ms;
    assign out_rec             = is_insert ? new_rec : rd_slot.rec;

    always_comb
    begin
        unique case (item_reg.command)
            CMD_INSERT:             hit = !rd_slot.valid;
            CMD_LOOKUP, CMD_REMOVE: hit = rd_slot.valid;
            CMD_EXPIRE:             hit = rd_slot.valid && (age >= timeout_reg);
        endcase
        hit = hit && rd_vld_reg;
    end

    assign sts.hit        = hit;
    assign sts.issue_done = (left_reg == '0);
    assign sts.rd_pending = rd_vld_reg;
    assign sts.clr_last   = (clr_addr_reg == LAST_ID);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = rd_addr_reg;
        ram_wdata = '0;
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
        end
        else if (cmd.commit && (is_insert || frees_slot))
        begin
            ram_we          = 1'b1;
            ram_wdata.valid = is_insert;
            ram_wdata.rec   = out_rec;
        end
    end

    always_comb
    begin
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        left_next     = left_reg;
        rd_vld_next   = cmd.issue;
        rd_addr_next  = rd_addr_reg;
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        result_next   = result_reg;
        done_next     = cmd.commit || cmd.fail;

        if (cmd.clr_step)
        begin
            clr_addr_next = clr_addr_reg + FIRST_ID;
        end

        if (cmd.load)
        begin
            item_next = request;
            unique case (request.command)
                CMD_INSERT:
                begin
                    addr_next = ptr_reg;
                    left_next = LW'(ID_COUNT - 1);
                end
                CMD_LOOKUP, CMD_REMOVE:
                begin
                    addr_next = rid_wide[IDW-1:0];
                    left_next = rid_ok ? LW'(1) : '0;
                end
                CMD_EXPIRE:
                begin
                    addr_next = '0;
                    left_next = LW'(ID_COUNT);
                end
            endcase
        end

        if (cmd.issue)
        begin
            rd_addr_next = addr_reg;
            left_next    = left_reg - LW'(1);
            addr_next    = is_insert ? wrap_next(addr_reg) : addr_reg + FIRST_ID;
        end

        if (cmd.commit)
        begin
            if (is_insert)
            begin
                count_next = count_reg + FIRST_ID;
                ptr_next   = wrap_next(rd_addr_reg);
            end
            else if (frees_slot)
            begin
                count_next = count_reg - FIRST_ID;
            end
            result_next.status          = ST_OK;
            result_next.assigned_id     = to10(rd_addr_reg);
            result_next.out_client_id   = out_rec.client_txn;
            result_next.out_query_type  = out_rec.query_type;
            result_next.out_query_class = out_rec.query_class;
            result_next.out_start_time  = out_rec.start_time;
            result_next.active_entries  = to10(count_next);
        end
        else if (cmd.fail)
        begin
            result_next                = '0;
            result_next.status         = is_insert ? ST_FULL : ST_MISS;
            result_next.active_entries = to10(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RESET;
            ptr_reg      <= FIRST_ID;
            count_reg    <= '0;
            addr_reg     <= '0;
            left_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (timeout_we)
            begin
                timeout_reg <= timeout_data;
            end
            ptr_reg      <= ptr_next;
            count_reg    <= count_next;
            addr_reg     <= addr_next;
            left_reg     <= left_next;
            rd_vld_reg   <= rd_vld_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        rd_addr_reg <= rd_addr_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ src/pending_request_id_table.sv @@
// Top level of the pending request ID table: controller plus datapath.
// Depends on prit_pkg, prit_ctrl, prit_dp and the assertion macro header.
//
// Channel   Handshake           Payload
// -------   -----------------   ---------------------------
// request   start, busy         request (prit_pkg::req_t)
// result    done (one cycle)    result  (prit_pkg::rsp_t)
// config    timeout_we          timeout_data (32 bits)
//
// A transfer is taken when start is high and busy is low; busy rises on the next cycle.
// Slots are read one per cycle: a match ends the scan and shows done, and an item that reads
// all its slots with no match fails, as does a lookup or remove of an unusable ID, which reads
// none (insert reads up to ID_COUNT - 1 slots, expire up to ID_COUNT, lookup and remove one);
// busy falls with done. After reset a clearing pass writes every slot, with busy high.
// The result receiver cannot stall; done marks each result for exactly one cycle.
`timescale 1ns / 1ps
`include "pending_request_id_table_assert.svh"

module pending_request_id_table #(
    parameter int ID_COUNT = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  prit_pkg::req_t request,
    input  logic           timeout_we,
    input  logic [31:0]    timeout_data,
    output logic           done,
    output prit_pkg::rsp_t result
);

    import prit_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    prit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    prit_dp #(
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .timeout_we   (timeout_we),
        .timeout_data (timeout_data),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .result       (result)
    );

    `PRIT_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy && !done, "accepted transfer did not raise busy")
    `PRIT_ASSERT_SAME(a_done_needs_busy, done, $past(busy), "result without an item in progress")
    `PRIT_ASSERT_NEXT(a_done_single, done, !done, "two results for one transfer")
    `PRIT_ASSERT_SAME(a_fail_zero_id, done && (result.status != ST_OK), result.assigned_id == 10'd0, "failed result carries an ID")

endmodule

@@ tb/sv/pending_request_id_table_test.sv @@
// Self-checking testbench for the pending request ID table.
// Drives random and directed commands, predicts every response in a scoreboard class.
// Depends on prit_pkg and the pending_request_id_table RTL.
`timescale 1ns / 1ps

module pending_request_id_table_test;

    import prit_pkg::*;

    localparam int ID_COUNT = 1024;

    class request_table_checker;
        bit          valid [ID_COUNT];
        rec_t        records [ID_COUNT];
        int          next_id;
        logic [9:0]  active;
        logic [31:0] expiry_limit;
        rsp_t        expected_responses [$];
        int          mismatch_count;
        int          status_seen [4];
        int          peak_active;

        function new();
            next_id = 1;
            active = '0;
            expiry_limit = TIMEOUT_RESET;
            mismatch_count = 0;
            peak_active = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int wrap_id(int id);
            return (id >= ID_COUNT || id == 0) ? 1 : id;
        endfunction

        function rsp_t hit_response(int id);
            rsp_t rsp;
            rsp = '0;
            rsp.status = ST_OK;
            rsp.assigned_id = 10'(id);
            rsp.out_client_id = records[id].client_txn;
            rsp.out_query_type = records[id].query_type;
            rsp.out_query_class = records[id].query_class;
            rsp.out_start_time = records[id].start_time;
            return rsp;
        endfunction

        function void record_request(req_t r);
            rsp_t        rsp;
            int          id;
            int          n;
            int          found;
            logic [31:0] age;
            rsp = '0;
            rsp.status = ST_MISS;
            found = -1;
            case (r.command)
                CMD_INSERT:
                begin
                    rsp.status = ST_FULL;
                    id = wrap_id(next_id);
                    for (n = 0; n < ID_COUNT - 1 && found < 0; n++)
                    begin
                        if (!valid[id])
                            found = id;
                        else
                            id = wrap_id(id + 1);
                    end
                    if (found >= 0)
                    begin
                        valid[found] = 1'b1;
                        records[found].client_txn = r.client_txn;
                        records[found].query_type = r.query_type;
                        records[found].query_class = r.query_class;
                        records[found].start_time = r.time_ms;
                        active++;
                        next_id = wrap_id(found + 1);
                        rsp = hit_response(found);
                    end
                end
                CMD_LOOKUP, CMD_REMOVE:
                begin
                    id = r.request_id;
                    if (id != 0 && id < ID_COUNT && valid[id])
                    begin
                        if (r.command == CMD_REMOVE)
                        begin
                            valid[id] = 1'b0;
                            active--;
                        end
                        rsp = hit_response(id);
                    end
                end
                default:
                begin
                    for (id = 0; id < ID_COUNT && found < 0; id++)
                    begin
                        age = r.time_ms - records[id].start_time;
                        if (valid[id] && age >= expiry_limit)
                            found = id;
                    end
                    if (found >= 0)
                    begin
                        valid[found] = 1'b0;
                        active--;
                        rsp = hit_response(found);
                    end
                end
            endcase
            rsp.active_entries = active;
            if (int'(active) > peak_active)
                peak_active = active;
            expected_responses.push_back(rsp);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_responses.size() == 0)
            begin
                $error("response with no outstanding request: 0x%0h", got);
                mismatch_count++;
                return;
            end
            want = expected_responses.pop_front();
            status_seen[want.status]++;
            compare_field("status", want.status, got.status);
            compare_field("assigned_id", want.assigned_id, got.assigned_id);
            compare_field("out_client_id", want.out_client_id, got.out_client_id);
            compare_field("out_query_type", want.out_query_type, got.out_query_type);
            compare_field("out_query_class", want.out_query_class, got.out_query_class);
            compare_field("out_start_time", want.out_start_time, got.out_start_time);
            compare_field("active_entries", want.active_entries, got.active_entries);
        endfunction

        function logic [9:0] pick_active_id();
            int id;
            int tries;
            for (tries = 0; tries < 32; tries++)
            begin
                id = $urandom_range(1, ID_COUNT - 1);
                if (valid[id])
                    return 10'(id);
            end
            return 10'($urandom_range(0, ID_COUNT - 1));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        timeout_we;
    logic [31:0] timeout_data;
    logic        done;
    rsp_t        result;

    request_table_checker tracker;
    logic [31:0]          now_ms;
    int                   time_step;
    int                   transfers_sent;
    int                   settings_written;
    bit                   quiet_stretch;

    pending_request_id_table #(
        .ID_COUNT(ID_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .timeout_we(timeout_we),
        .timeout_data(timeout_data),
        .done(done),
        .result(result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            tracker.check_response(result);
    end

    function automatic req_t make_req(logic [1:0] cmd, logic [9:0] id, logic [31:0] t,
                                      logic [15:0] client, logic [15:0] qtype,
                                      logic [15:0] qclass);
        req_t r;
        r.command = cmd;
        r.client_txn = client;
        r.query_type = qtype;
        r.query_class = qclass;
        r.time_ms = t;
        r.request_id = id;
        return r;
    endfunction

    function automatic req_t random_req(logic [1:0] cmd, logic [9:0] id, logic [31:0] t);
        return make_req(cmd, id, t, 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    task automatic send(req_t r);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        tracker.record_request(r);
        transfers_sent++;
        if (transfers_sent % 40 == 0)
            quiet_stretch = ($urandom_range(0, 3) == 0);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (tracker.expected_responses.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        settle();
        timeout_we <= 1'b1;
        timeout_data <= value;
        tracker.expiry_limit = value;
        settings_written++;
        @(posedge clk);
        timeout_we <= 1'b0;
    endtask

    task automatic random_item(int insert_weight);
        int          pick;
        logic [1:0]  cmd;
        logic [9:0]  id;
        logic [31:0] t;
        pick = $urandom_range(0, 99);
        now_ms = now_ms + $urandom_range(0, time_step);
        t = ($urandom_range(0, 19) == 0) ? $urandom : now_ms;
        if (pick < insert_weight)
            cmd = CMD_INSERT;
        else if (pick < insert_weight + 15)
            cmd = CMD_LOOKUP;
        else if (pick < insert_weight + 35)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_EXPIRE;
        id = ($urandom_range(0, 9) == 0) ? 10'($urandom) : tracker.pick_active_id();
        send(random_req(cmd, id, t));
    endtask

    initial
    begin
        tracker = new();
        transfers_sent = 0;
        settings_written = 0;
        quiet_stretch = 1'b0;
        now_ms = 32'd1000;
        time_step = 200;
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        timeout_we <= 1'b0;
        timeout_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        send(random_req(CMD_LOOKUP, 10'd0, now_ms));
        send(random_req(CMD_REMOVE, 10'd0, now_ms));
        send(random_req(CMD_EXPIRE, 10'd0, now_ms));
        send(random_req(CMD_LOOKUP, 10'd1023, now_ms));
        send(make_req(CMD_INSERT, 10'd0, 32'hFFFF_FFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send(make_req(CMD_INSERT, 10'h3FF, 32'd0, 16'h0000, 16'h0000, 16'h0000));
        send(random_req(CMD_LOOKUP, 10'd1, now_ms));
        send(random_req(CMD_LOOKUP, 10'd2, now_ms));
        send(random_req(CMD_EXPIRE, 10'd0, 32'd1984));
        send(random_req(CMD_EXPIRE, 10'd0, 32'd1999));
        send(random_req(CMD_EXPIRE, 10'd0, 32'd2000));
        send(random_req(CMD_INSERT, 10'd0, now_ms));
        send(random_req(CMD_REMOVE, 10'd3, now_ms));
        send(random_req(CMD_REMOVE, 10'd3, now_ms));
        send(random_req(CMD_LOOKUP, 10'd3, now_ms));
        send(random_req(CMD_REMOVE, 10'd5, now_ms));

        write_timeout(32'hFFFF_FFFF);
        send(random_req(CMD_INSERT, 10'd0, 32'd5));
        send(random_req(CMD_EXPIRE, 10'd0, 32'd3));
        send(random_req(CMD_EXPIRE, 10'd0, 32'd4));

        write_timeout(32'd0);
        send(random_req(CMD_INSERT, 10'd0, 32'd100));
        send(random_req(CMD_EXPIRE, 10'd0, 32'd100));
        send(random_req(CMD_EXPIRE, 10'd0, 32'd100));

        write_timeout(TIMEOUT_RESET);
        repeat (270) random_item(55);

        write_timeout(32'd50);
        time_step = 20;
        repeat (100) random_item(50);

        // Push occupancy up with insert-heavy traffic while entries almost never expire.
        write_timeout(32'hFFFF_FFFF);
        time_step = 1000;
        repeat (250) random_item(90);
        repeat (100) random_item(40);

        write_timeout(32'd0);
        repeat (40) send(random_req(CMD_EXPIRE, 10'($urandom), $urandom));

        write_timeout($urandom);
        time_step = 1_000_000;
        repeat (60) random_item(30);

        settle();
        repeat (1100) @(posedge clk);
        $display("Sent %0d transfers under %0d timeout settings; peak occupancy %0d of %0d IDs.",
                 transfers_sent, settings_written, tracker.peak_active, ID_COUNT - 1);
        $display("Responses: %0d success, %0d table full, %0d no match or nothing expired.",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
                 tracker.status_seen[ST_MISS]);
        if (tracker.mismatch_count == 0 && tracker.expected_responses.size() == 0)
            $display("pending_request_id_table_test passed");
        else
            $display("pending_request_id_table_test failed");
        $finish;
    end

    initial
    begin
        #(25_000_000);
        $display("Timed out with %0d responses outstanding.",
                 tracker.expected_responses.size());
        $display("pending_request_id_table_test failed");
        $finish;
    end

endmodule

@@ pending_request_id_table.f @@
+incdir+src
src/prit_pkg.sv
src/prit_ram.sv
src/prit_ctrl.sv
src/prit_dp.sv
src/pending_request_id_table.sv
tb/sv/pending_request_id_table_test.sv
